### design/assert_macros.svh
// shared assertion macros, sampled on clk and held off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// same, but the consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/fdes_pkg.sv
package fdes_pkg;

	localparam int ENTRY_BYTES = 32;
	localparam int NAME_BYTES  = 11;

	// entry field offsets
	localparam logic [4:0] OFF_ATTR    = 5'h0b;
	localparam logic [4:0] OFF_STAMP   = 5'h16;
	localparam logic [4:0] OFF_CLUSTER = 5'h1a;
	localparam logic [4:0] OFF_SIZE    = 5'h1c;
	localparam logic [4:0] ENTRY_LAST  = 5'(ENTRY_BYTES - 1);

	// result status codes
	localparam logic [1:0] STATUS_FOUND     = 2'd0;
	localparam logic [1:0] STATUS_END_DIR   = 2'd1;
	localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_NAME_LOW      = 2'd0;
	localparam logic [1:0] REG_NAME_HIGH     = 2'd1;
	localparam logic [1:0] REG_SECTOR_BYTES  = 2'd2;
	localparam logic [1:0] REG_BLOCK_SECTORS = 2'd3;

	localparam int CFG_DATA_W = 64;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       block_start;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] start_cluster;
		logic [31:0] file_size;
		logic [7:0]  attributes;
		logic [31:0] date_time;
	} out_item_t;

	typedef struct packed {
		logic [63:0] name_low;
		logic [23:0] name_high;
		logic [12:0] sector_bytes;
		logic [15:0] block_sectors;
	} cfg_t;

	typedef struct packed {
		logic      hit;
		out_item_t item;
	} scan_res_t;

endpackage

### design/fdes_scan.sv
module fdes_scan #(
	parameter int MAX_SECTOR_BYTES = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	input  logic                advance,
	input  fdes_pkg::in_item_t  item,
	input  fdes_pkg::cfg_t      cfg,
	output fdes_pkg::scan_res_t res
);
	import fdes_pkg::*;

	localparam int BW = $clog2(MAX_SECTOR_BYTES);
	localparam int CW = (BW + 1 > 13) ? BW + 1 : 13;

	logic [BW-1:0] byte_in_sector_q, bis_base, bis_n;
	logic [15:0]   sector_index_q, sec_base, sec_n;
	logic [4:0]    entry_byte_q, e, e_n;
	logic          name_equal_q, neq_base, neq_n;
	logic          leading_zero_q, lz_base, lz_n;
	logic [15:0]   cluster_q, cluster_n;
	logic [31:0]   size_q, size_n;
	logic [7:0]    attr_q, attr_n;
	logic [31:0]   stamp_q, stamp_n;
	logic          idle_q, idle_n;
	logic          active;
	logic [87:0]   name_vec;
	logic [3:0]    nidx;
	logic [7:0]    name_char;
	logic [12:0]   sb_round;
	logic [CW-1:0] eff_bytes;
	logic [15:0]   nsec;
	logic          sector_end, block_end;
	logic          restart_entry;

	assign name_vec = {cfg.name_high, cfg.name_low};
	assign sb_round = {cfg.sector_bytes[12:5], 5'b0};
	assign nsec     = (cfg.block_sectors == 16'd0) ? 16'd1 : cfg.block_sectors;

	always_comb begin
		if (CW'(sb_round) < CW'(ENTRY_BYTES))
			eff_bytes = CW'(ENTRY_BYTES);
		else if (CW'(sb_round) > CW'(MAX_SECTOR_BYTES))
			eff_bytes = CW'(MAX_SECTOR_BYTES);
		else
			eff_bytes = CW'(sb_round);
	end

	always_comb begin
		active = item.block_start || !idle_q;

		// a start byte opens a fresh search with this very byte
		if (item.block_start) begin
			bis_base  = '0;
			sec_base  = '0;
			e         = '0;
			neq_base  = 1'b1;
			lz_base   = 1'b0;
			cluster_n = '0;
			size_n    = '0;
			attr_n    = '0;
			stamp_n   = '0;
		end else begin
			bis_base  = byte_in_sector_q;
			sec_base  = sector_index_q;
			e         = entry_byte_q;
			neq_base  = name_equal_q;
			lz_base   = leading_zero_q;
			cluster_n = cluster_q;
			size_n    = size_q;
			attr_n    = attr_q;
			stamp_n   = stamp_q;
		end

		nidx      = (e < 5'(NAME_BYTES)) ? e[3:0] : 4'd0;
		name_char = name_vec[{nidx, 3'b0} +: 8];
		neq_n     = neq_base && !((e < 5'(NAME_BYTES)) && (item.data_byte != name_char));
		lz_n      = (e == 5'd0) ? (item.data_byte == 8'd0) : lz_base;

		unique case (e)
			OFF_ATTR:          attr_n          = item.data_byte;
			OFF_STAMP:         stamp_n[7:0]    = item.data_byte;
			OFF_STAMP + 5'd1:  stamp_n[15:8]   = item.data_byte;
			OFF_STAMP + 5'd2:  stamp_n[23:16]  = item.data_byte;
			OFF_STAMP + 5'd3:  stamp_n[31:24]  = item.data_byte;
			OFF_CLUSTER:       cluster_n[7:0]  = item.data_byte;
			OFF_CLUSTER + 5'd1: cluster_n[15:8] = item.data_byte;
			OFF_SIZE:          size_n[7:0]     = item.data_byte;
			OFF_SIZE + 5'd1:   size_n[15:8]    = item.data_byte;
			OFF_SIZE + 5'd2:   size_n[23:16]   = item.data_byte;
			OFF_SIZE + 5'd3:   size_n[31:24]   = item.data_byte;
			default: ;
		endcase

		sector_end = (CW'(bis_base) + CW'(1)) >= eff_bytes;
		block_end  = sector_end && ((17'(sec_base) + 17'd1) >= 17'(nsec));
		bis_n      = sector_end ? '0 : bis_base + BW'(1);
		sec_n      = sector_end ? sec_base + 16'd1 : sec_base;

		res           = '0;
		idle_n        = idle_q;
		restart_entry = 1'b0;
		e_n           = e + 5'd1;
		if (active) begin
			idle_n = 1'b0;
			priority if (e == ENTRY_LAST && neq_n) begin
				res.hit                = 1'b1;
				res.item.status        = STATUS_FOUND;
				res.item.start_cluster = cluster_n;
				res.item.file_size     = size_n;
				res.item.attributes    = attr_n;
				res.item.date_time     = stamp_n;
				idle_n                 = 1'b1;
			end else if (e == ENTRY_LAST && lz_n) begin
				res.hit         = 1'b1;
				res.item.status = STATUS_END_DIR;
				idle_n          = 1'b1;
			end else if (block_end) begin
				res.hit         = 1'b1;
				res.item.status = STATUS_EXHAUSTED;
				idle_n          = 1'b1;
				restart_entry   = (e == ENTRY_LAST);
			end else begin
				restart_entry = (e == ENTRY_LAST);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_in_sector_q <= '0;
			sector_index_q   <= '0;
			entry_byte_q     <= '0;
			name_equal_q     <= 1'b1;
			leading_zero_q   <= 1'b0;
			cluster_q        <= '0;
			size_q           <= '0;
			attr_q           <= '0;
			stamp_q          <= '0;
			idle_q           <= 1'b1;
		end else if (valid && advance && active) begin
			byte_in_sector_q <= bis_n;
			sector_index_q   <= sec_n;
			idle_q           <= idle_n;
			if (restart_entry) begin
				entry_byte_q   <= '0;
				name_equal_q   <= 1'b1;
				leading_zero_q <= 1'b0;
				cluster_q      <= '0;
				size_q         <= '0;
				attr_q         <= '0;
				stamp_q        <= '0;
			end else begin
				entry_byte_q   <= e_n;
				name_equal_q   <= neq_n;
				leading_zero_q <= lz_n;
				cluster_q      <= cluster_n;
				size_q         <= size_n;
				attr_q         <= attr_n;
				stamp_q        <= stamp_n;
			end
		end
	end

endmodule

### design/fat_directory_entry_scanner_top.sv
// fat directory entry scanner
// item channel (item_valid/item_ready/item): one directory byte per beat, with
// block_start set on the first byte of a new search; a start in mid search
// drops the old one. result channel (result_valid/result_ready/result): one
// beat per decision - found (with cluster, size, attribute, date/time),
// end of directory, or block exhausted. the name, sector size and sector
// count are written through cfg_we/cfg_index/cfg_data; the user must write
// them only while no search runs; the block does not enforce this.
// a byte taken into the input stage is scanned there and, if it decides,
// its result is loaded into the result register (two register stages).
// throughput is one byte per cycle unless a deciding byte waits on a full
// result register, bounded by the single compare and capture step between stages.
// while a result waits on result_ready, bytes that cause no result keep
// flowing; a byte that decides waits in the input stage until the result
// register frees, and item_ready drops behind it.
// reset clears both stages and leaves the scanner idle, waiting for a start
// byte; the name registers clear, sector size goes to 512, sector count to 1.
module fat_directory_entry_scanner_top #(
	parameter int MAX_SECTOR_BYTES = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  fdes_pkg::in_item_t    item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output fdes_pkg::out_item_t   result,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [fdes_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fdes_pkg::*;
	`include "assert_macros.svh"

	cfg_t      cfg_q;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      advance;
	scan_res_t res;
	logic      out_valid_q;
	out_item_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.name_low      <= '0;
			cfg_q.name_high     <= '0;
			cfg_q.sector_bytes  <= 13'd512;
			cfg_q.block_sectors <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NAME_LOW:      cfg_q.name_low      <= cfg_data;
				REG_NAME_HIGH:     cfg_q.name_high     <= cfg_data[23:0];
				REG_SECTOR_BYTES:  cfg_q.sector_bytes  <= cfg_data[12:0];
				REG_BLOCK_SECTORS: cfg_q.block_sectors <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// the input stage moves on unless it decides and the result slot is full
	assign advance    = valid_s1 && (!res.hit || !out_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid)
			item_s1 <= item;
	end

	fdes_scan #(
		.MAX_SECTOR_BYTES(MAX_SECTOR_BYTES)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid   (valid_s1),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.hit) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.hit)
			out_q <= res.item;
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	`ASSERT_NEXT(a_s1_held, valid_s1 && !advance, valid_s1 && $stable(item_s1),
		"input stage lost a stalled byte")
	`ASSERT_NEXT(a_hit_loads, advance && res.hit, out_valid_q,
		"decision did not reach the result register")
	`ASSERT_CLK(a_no_data_on_miss,
		out_valid_q && out_q.status != STATUS_FOUND |->
		out_q.start_cluster == '0 && out_q.file_size == '0 &&
		out_q.attributes == '0 && out_q.date_time == '0,
		"non-found result carries entry data")

endmodule

### tb/sv/tb.sv
module tb;
	import fdes_pkg::*;

	localparam int MAX_SECTOR_BYTES = 4096;
	localparam int STALL_LIMIT      = 2000;
	localparam int PIPE_CYCLES      = 4;

	typedef enum {ENT_MATCH, ENT_END_MARK, ENT_NEAR_MISS, ENT_RANDOM} entry_kind_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	in_item_t    item = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	out_item_t   result;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_NAME_LOW;
	logic [63:0] cfg_data = '0;

	fat_directory_entry_scanner_top #(
		.MAX_SECTOR_BYTES(MAX_SECTOR_BYTES)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the search registers
	logic [63:0] srch_name_low = '0;
	logic [23:0] srch_name_high = '0;
	logic [12:0] sect_bytes_q = 13'd512;
	logic [15:0] blk_sectors_q = 16'd1;

	// scanner state as the predictor sees it
	int          scan_offset = 0;
	int          scan_sector = 0;
	int          entry_pos = 0;
	bit          name_ok = 1'b1;
	bit          first_zero = 1'b0;
	logic [15:0] cluster_cap = '0;
	logic [31:0] size_cap = '0;
	logic [7:0]  attr_cap = '0;
	logic [31:0] stamp_cap = '0;
	bit          scan_idle = 1'b1;

	out_item_t   pending_decisions[$];
	int          mismatch_count = 0;
	int          send_idle_pct = 29;
	int          recv_idle_pct = 74;
	int          stall_cycles = 0;
	logic [7:0]  entry_buf[ENTRY_BYTES];

	function automatic logic [7:0] name_char(input int pos);
		if (pos < 8)
			return srch_name_low[8*pos +: 8];
		return srch_name_high[8*(pos-8) +: 8];
	endfunction

	function automatic void open_entry();
		entry_pos   = 0;
		name_ok     = 1'b1;
		first_zero  = 1'b0;
		cluster_cap = '0;
		size_cap    = '0;
		attr_cap    = '0;
		stamp_cap   = '0;
	endfunction

	function automatic bit scan_directory_byte(input logic [7:0] b, input logic s,
		output out_item_t r);
		int pos;
		int eff;
		int nsec;
		bit sector_end;
		bit block_end;
		r = '0;
		if (s) begin
			scan_offset = 0;
			scan_sector = 0;
			open_entry();
			scan_idle = 1'b0;
		end else if (scan_idle) begin
			return 1'b0;
		end
		pos = entry_pos;
		if (pos < NAME_BYTES && b != name_char(pos))
			name_ok = 1'b0;
		if (pos == 0)
			first_zero = (b == 8'h00);
		if (pos == OFF_ATTR)
			attr_cap = b;
		if (pos >= OFF_STAMP && pos < OFF_STAMP + 4)
			stamp_cap |= 32'(b) << (8 * (pos - OFF_STAMP));
		if (pos >= OFF_CLUSTER && pos < OFF_CLUSTER + 2)
			cluster_cap |= 16'(b) << (8 * (pos - OFF_CLUSTER));
		if (pos >= OFF_SIZE && pos < OFF_SIZE + 4)
			size_cap |= 32'(b) << (8 * (pos - OFF_SIZE));

		// sector size rounds down to whole entries, then clamps
		eff = int'(sect_bytes_q) & ~(ENTRY_BYTES - 1);
		if (eff < ENTRY_BYTES)
			eff = ENTRY_BYTES;
		if (eff > MAX_SECTOR_BYTES)
			eff = MAX_SECTOR_BYTES;
		nsec = (blk_sectors_q == 16'd0) ? 1 : int'(blk_sectors_q);
		sector_end = (scan_offset + 1 >= eff);
		block_end  = sector_end && (scan_sector + 1 >= nsec);
		if (sector_end) begin
			scan_offset = 0;
			scan_sector = (scan_sector + 1) & 16'hffff;
		end else begin
			scan_offset = scan_offset + 1;
		end

		// an entry decision on the last byte of the block wins over exhaustion
		if (pos == ENTRY_BYTES - 1) begin
			if (name_ok) begin
				scan_idle       = 1'b1;
				r.status        = STATUS_FOUND;
				r.start_cluster = cluster_cap;
				r.file_size     = size_cap;
				r.attributes    = attr_cap;
				r.date_time     = stamp_cap;
				return 1'b1;
			end
			if (first_zero) begin
				scan_idle = 1'b1;
				r.status  = STATUS_END_DIR;
				return 1'b1;
			end
			open_entry();
		end else begin
			entry_pos = pos + 1;
		end
		if (block_end) begin
			scan_idle = 1'b1;
			r.status  = STATUS_EXHAUSTED;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	always @(posedge clk) begin : track_bytes
		out_item_t decided;
		if (arst_n && item_valid && item_ready) begin
			if (scan_directory_byte(item.data_byte, item.block_start, decided))
				pending_decisions.push_back(decided);
		end
	end

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_decisions.size() == 0) begin
				$display("%0t unexpected result: status %0d cluster %h size %h attr %h stamp %h",
					$time, result.status, result.start_cluster, result.file_size,
					result.attributes, result.date_time);
				mismatch_count++;
			end else begin
				want = pending_decisions.pop_front();
				if (result.status !== want.status ||
					result.start_cluster !== want.start_cluster ||
					result.file_size !== want.file_size ||
					result.attributes !== want.attributes ||
					result.date_time !== want.date_time) begin
					$display("%0t mismatch: expected status %0d cluster %h size %h attr %h stamp %h",
						$time, want.status, want.start_cluster, want.file_size,
						want.attributes, want.date_time);
					$display("%0t           actual status %0d cluster %h size %h attr %h stamp %h",
						$time, result.status, result.start_cluster, result.file_size,
						result.attributes, result.date_time);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk)
		result_ready <= ($urandom_range(99) >= recv_idle_pct);

	// nothing moving for too long means the block is stuck
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || cfg_we) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("[fat_directory_entry_scanner_top] ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send_byte(input logic [7:0] d, input logic s);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid        <= 1'b1;
		item.data_byte    <= d;
		item.block_start  <= s;
		do
			@(posedge clk);
		while (!item_ready);
	endtask

	// let the pipeline drain, then wait out all decisions before touching registers
	task automatic settle();
		item_valid <= 1'b0;
		repeat (PIPE_CYCLES) @(posedge clk);
		while (pending_decisions.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_search_regs(input logic [63:0] nl, input logic [23:0] nh,
		input logic [12:0] sb, input logic [15:0] ns);
		srch_name_low  = nl;
		srch_name_high = nh;
		sect_bytes_q   = sb;
		blk_sectors_q  = ns;
		cfg_we    <= 1'b1;
		cfg_index <= REG_NAME_LOW;
		cfg_data  <= nl;
		@(posedge clk);
		cfg_index <= REG_NAME_HIGH;
		cfg_data  <= {40'd0, nh};
		@(posedge clk);
		cfg_index <= REG_SECTOR_BYTES;
		cfg_data  <= {51'd0, sb};
		@(posedge clk);
		cfg_index <= REG_BLOCK_SECTORS;
		cfg_data  <= {48'd0, ns};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] field_byte();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic void build_entry(input entry_kind_t kind);
		int i;
		int p;
		for (i = 0; i < ENTRY_BYTES; i++)
			entry_buf[i] = field_byte();
		case (kind)
			ENT_MATCH: begin
				for (i = 0; i < NAME_BYTES; i++)
					entry_buf[i] = name_char(i);
			end
			ENT_NEAR_MISS: begin
				for (i = 0; i < NAME_BYTES; i++)
					entry_buf[i] = name_char(i);
				p = $urandom_range(NAME_BYTES - 1);
				entry_buf[p] = name_char(p) ^ 8'($urandom_range(1, 255));
			end
			ENT_END_MARK: begin
				entry_buf[0] = 8'h00;
			end
			default: ;
		endcase
	endfunction

	task automatic send_entry(input bit with_start, input int count);
		int i;
		for (i = 0; i < count; i++)
			send_byte(entry_buf[i], with_start && i == 0);
	endtask

	// a matching entry with a fresh start always leaves the scanner idle
	task automatic close_search();
		build_entry(ENT_MATCH);
		send_entry(1'b1, ENTRY_BYTES);
	endtask

	localparam logic [63:0] README_LOW = 64'h2020_454d_4441_4552;
	localparam logic [23:0] TXT_HIGH   = 24'h54_5854;

	task automatic test_reset_defaults();
		int i;
		// idle scanner ignores bytes without a start
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'ha5, 1'b0);
		// reset name is all zero, so an all-zero entry is found, not end of directory
		for (i = 0; i < ENTRY_BYTES; i++)
			entry_buf[i] = 8'h00;
		send_entry(1'b1, ENTRY_BYTES);
	endtask

	task automatic test_found_entry();
		int i;
		settle();
		write_search_regs(README_LOW, TXT_HIGH, 13'd32, 16'd2);
		build_entry(ENT_MATCH);
		for (i = NAME_BYTES; i < ENTRY_BYTES; i++)
			entry_buf[i] = 8'hff;
		send_entry(1'b1, ENTRY_BYTES);
		// byte offsets as data show the little-endian packing
		build_entry(ENT_MATCH);
		for (i = NAME_BYTES; i < ENTRY_BYTES; i++)
			entry_buf[i] = 8'(i);
		send_entry(1'b1, ENTRY_BYTES);
	endtask

	task automatic test_end_marker();
		build_entry(ENT_NEAR_MISS);
		entry_buf[0] = 8'he5;
		send_entry(1'b1, ENTRY_BYTES);
		build_entry(ENT_END_MARK);
		entry_buf[1] = ~name_char(1);
		send_entry(1'b0, ENTRY_BYTES);
	endtask

	task automatic test_block_exhausted();
		build_entry(ENT_RANDOM);
		entry_buf[0] = 8'he5;
		send_entry(1'b1, ENTRY_BYTES);
		build_entry(ENT_NEAR_MISS);
		entry_buf[0] = 8'he5;
		send_entry(1'b0, ENTRY_BYTES);
	endtask

	task automatic test_decision_at_block_end();
		settle();
		write_search_regs(README_LOW, TXT_HIGH, 13'd32, 16'd1);
		close_search();
		build_entry(ENT_END_MARK);
		entry_buf[2] = ~name_char(2);
		send_entry(1'b1, ENTRY_BYTES);
	endtask

	task automatic test_restart();
		build_entry(ENT_RANDOM);
		send_entry(1'b1, 10);
		close_search();
	endtask

	task automatic test_odd_geometry();
		settle();
		write_search_regs(README_LOW, TXT_HIGH, 13'd63, 16'd0);
		build_entry(ENT_RANDOM);
		entry_buf[0] = 8'he5;
		send_entry(1'b1, ENTRY_BYTES);
		settle();
		write_search_regs(README_LOW, TXT_HIGH, 13'd0, 16'd0);
		build_entry(ENT_RANDOM);
		entry_buf[0] = 8'he5;
		send_entry(1'b1, ENTRY_BYTES);
		settle();
		write_search_regs(README_LOW, TXT_HIGH, 13'h1fff, 16'hffff);
		build_entry(ENT_NEAR_MISS);
		send_entry(1'b1, ENTRY_BYTES);
		build_entry(ENT_MATCH);
		send_entry(1'b0, ENTRY_BYTES);
	endtask

	task automatic test_name_extremes();
		int i;
		settle();
		write_search_regs('1, '1, 13'd64, 16'd1);
		for (i = 0; i < ENTRY_BYTES; i++)
			entry_buf[i] = 8'hff;
		send_entry(1'b1, ENTRY_BYTES);
		build_entry(ENT_RANDOM);
		entry_buf[0] = 8'h7f;
		send_entry(1'b1, ENTRY_BYTES);
		build_entry(ENT_RANDOM);
		entry_buf[0] = 8'he5;
		send_entry(1'b0, ENTRY_BYTES);
	endtask

	task automatic apply_setting(input int sel);
		logic [63:0] nl;
		logic [23:0] nh;
		nl = {$urandom, $urandom};
		nh = 24'($urandom);
		case (sel)
			0: write_search_regs(nl, nh, 13'd32, 16'd1);
			1: write_search_regs('0, '0, 13'd64, 16'd2);
			2: write_search_regs('1, '1, 13'd33, 16'd3);
			3: write_search_regs(nl, nh, 13'd0, 16'd0);
			4: write_search_regs(nl, nh, 13'h1fff, 16'hffff);
			5: write_search_regs(nl, nh, 13'd96, 16'hffff);
			6: write_search_regs(nl, nh, 13'($urandom_range(0, 8191)),
				16'($urandom_range(0, 4)));
			default: write_search_regs(nl, nh, 13'd4096, 16'd1);
		endcase
	endtask

	task automatic run_searches(input int byte_budget);
		int sent;
		int n_ent;
		int k;
		int cut;
		int roll;
		entry_kind_t kind;
		sent = 0;
		while (sent < byte_budget) begin
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
			n_ent = $urandom_range(1, 4);
			for (k = 0; k < n_ent; k++) begin
				roll = $urandom_range(99);
				if (roll < 15)
					kind = ENT_MATCH;
				else if (roll < 25)
					kind = ENT_END_MARK;
				else if (roll < 80)
					kind = ENT_NEAR_MISS;
				else
					kind = ENT_RANDOM;
				build_entry(kind);
				// now and then cut an entry short so the next start restarts mid search
				cut = ($urandom_range(99) < 4) ? $urandom_range(1, ENTRY_BYTES - 1) : ENTRY_BYTES;
				send_entry(k == 0, cut);
				sent += cut;
				if (cut < ENTRY_BYTES)
					break;
			end
		end
	endtask

	task automatic test_random_traffic(input int first_setting, input int n_settings,
		input int byte_budget);
		int s;
		for (s = first_setting; s < first_setting + n_settings; s++) begin
			settle();
			apply_setting(s);
			run_searches(byte_budget);
			close_search();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 29;
		recv_idle_pct = 74;
		test_reset_defaults();
		test_found_entry();
		test_end_marker();
		test_block_exhausted();
		test_decision_at_block_end();
		test_restart();
		test_odd_geometry();
		test_name_extremes();
		test_random_traffic(0, 3, 1);
		send_idle_pct = 74;
		recv_idle_pct = 29;
		test_random_traffic(3, 3, 1);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(6, 2, 1);
		settle();
		if (mismatch_count == 0)
			$display("[fat_directory_entry_scanner_top] OK");
		else
			$display("[fat_directory_entry_scanner_top] ERROR");
		$finish;
	end

endmodule

### fat_directory_entry_scanner_top.f
+incdir+design
design/fdes_pkg.sv
design/fdes_scan.sv
design/fat_directory_entry_scanner_top.sv
tb/sv/tb.sv
